// ===== design/lsbse_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types and codes for the lsb stego extractor: item structs, status
// codes and configuration register indexes.
// ----------------------------------------------------------------------------
package lsbse_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DIM_W    = 15;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DATA  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LONG  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SMALL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  // one cover image byte
  typedef struct packed {
    logic [BYTE_W-1:0] cover_byte;
    logic              first_of_image;
  } in_item_t;

  // one recovered result
  typedef struct packed {
    logic [BYTE_W-1:0]   message_byte;
    logic                last_of_message;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

// ===== design/lsb_stego_extractor.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_extractor
// Recovers a message hidden in the low bits of RGBA image bytes: mode byte,
// 32-bit byte-swapped length, then message bytes with a last flag and status.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in_     | input     | in_valid / in_stall  | lsbse_pkg::in_item_t
//   out_    | output    | out_valid / out_stall| lsbse_pkg::out_item_t
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle while the result side does not stall; a transferred byte
// passes through the input register and the parse logic into the result
// register. Synchronous active-low reset clears the parser and sets both
// image dimensions to 1. A stalled result holds the result register; the
// input side stalls only when the input register cannot move on.
// cfg_ready is always high.

module lsb_stego_extractor (
  input  logic                               clk,
  input  logic                               rst_n,
  // input byte channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lsbse_pkg::in_item_t                in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output lsbse_pkg::out_item_t               out_data,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lsbse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsbse_pkg::DIM_W-1:0]        cfg_data
);

  // parser phases
  localparam logic [1:0] PH_MODE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam int unsigned PROD_W = 2 * lsbse_pkg::DIM_W;

  // capacity for each symbol width, wrapping to 32 bits
  function automatic logic [31:0] cap_of(input logic [PROD_W-1:0] prod,
                                          input logic [2:0] k);
    logic [31:0] p32;
    logic [31:0] res;
    p32 = {{(32-PROD_W){1'b0}}, prod};
    case (k)
      3'd1:    res = (p32 >> 1) - 32'd33;
      3'd2:    res = p32 - 32'd17;
      default: res = (p32 << 1) - 32'd9;
    endcase
    return res;
  endfunction

  // configuration registers
  logic [lsbse_pkg::DIM_W-1:0] image_width_r;
  logic [lsbse_pkg::DIM_W-1:0] image_height_r;
  logic [PROD_W-1:0]           pixels_r;

  // input register
  logic                  s_valid_r;
  lsbse_pkg::in_item_t   s_item_r;

  // parser state
  logic [1:0]  phase_r,         phase_nxt;
  logic [2:0]  symbol_width_r,  symbol_width_nxt;
  logic [31:0] length_gather_r, length_gather_nxt;
  logic [4:0]  chunk_offset_r,  chunk_offset_nxt;
  logic [7:0]  byte_gather_r,   byte_gather_nxt;
  logic [31:0] bytes_left_r,    bytes_left_nxt;

  // result register
  logic                  out_valid_r;
  lsbse_pkg::out_item_t  out_item_r;
  logic                  emit;
  lsbse_pkg::out_item_t  res_item;

  logic        advance;
  logic [1:0]  ph;
  logic [3:0]  chunk;
  logic [5:0]  off_sum;
  logic [31:0] len_full;
  logic [31:0] len_swap;
  logic [31:0] cap_sel;
  logic [7:0]  byte_full;
  logic [31:0] left_dec;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // the input register moves when the result register is free or drains
  assign advance  = s_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s_valid_r && !advance;

  // configuration writes and pixel count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= lsbse_pkg::DIM_W'(1);
      image_height_r <= lsbse_pkg::DIM_W'(1);
      pixels_r       <= PROD_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lsbse_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
          lsbse_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
          default: ;
        endcase
      end
      pixels_r <= PROD_W'(image_width_r) * PROD_W'(image_height_r);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_item_r <= in_data;
    end
  end

  // chunk extraction and gather arithmetic
  always_comb begin
    case (symbol_width_r)
      3'd1:    chunk = {3'b000, s_item_r.cover_byte[0]};
      3'd2:    chunk = {2'b00, s_item_r.cover_byte[1:0]};
      default: chunk = s_item_r.cover_byte[3:0];
    endcase
    cap_sel   = cap_of(pixels_r, symbol_width_r);
    off_sum   = {1'b0, chunk_offset_r} + {3'b000, symbol_width_r};
    len_full  = length_gather_r | ({28'd0, chunk} << chunk_offset_r);
    len_swap  = {len_full[7:0], len_full[15:8], len_full[23:16], len_full[31:24]};
    byte_full = byte_gather_r | 8'({4'd0, chunk} << chunk_offset_r[2:0]);
    left_dec  = bytes_left_r - 32'd1;
  end

  // parser next state and result
  always_comb begin
    phase_nxt         = phase_r;
    symbol_width_nxt  = symbol_width_r;
    length_gather_nxt = length_gather_r;
    chunk_offset_nxt  = chunk_offset_r;
    byte_gather_nxt   = byte_gather_r;
    bytes_left_nxt    = bytes_left_r;
    emit              = 1'b0;
    res_item          = '0;
    res_item.status   = lsbse_pkg::ST_DATA;

    ph = s_item_r.first_of_image ? PH_MODE : phase_r;

    unique case (ph)
      PH_MODE: begin
        length_gather_nxt = '0;
        chunk_offset_nxt  = '0;
        byte_gather_nxt   = '0;
        bytes_left_nxt    = '0;
        symbol_width_nxt  = {1'b0, s_item_r.cover_byte[1:0]} + 3'd1;
        if (pixels_r < PROD_W'(5)) begin
          phase_nxt                = PH_DONE;
          emit                     = 1'b1;
          res_item.last_of_message = 1'b1;
          res_item.status          = lsbse_pkg::ST_SMALL;
        end else if (s_item_r.cover_byte[1:0] == 2'd2) begin
          phase_nxt                = PH_DONE;
          emit                     = 1'b1;
          res_item.last_of_message = 1'b1;
          res_item.status          = lsbse_pkg::ST_BADW;
        end else begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        length_gather_nxt = len_full;
        if (off_sum >= 6'd32) begin
          chunk_offset_nxt = '0;
          if (len_swap > cap_sel) begin
            phase_nxt                = PH_DONE;
            emit                     = 1'b1;
            res_item.last_of_message = 1'b1;
            res_item.status          = lsbse_pkg::ST_LONG;
          end else if (len_swap == 32'd0) begin
            phase_nxt                = PH_DONE;
            emit                     = 1'b1;
            res_item.last_of_message = 1'b1;
            res_item.status          = lsbse_pkg::ST_EMPTY;
          end else begin
            bytes_left_nxt  = len_swap;
            byte_gather_nxt = '0;
            phase_nxt       = PH_DATA;
          end
        end else begin
          chunk_offset_nxt = off_sum[4:0];
        end
      end
      PH_DATA: begin
        if (off_sum >= 6'd8) begin
          chunk_offset_nxt      = '0;
          byte_gather_nxt       = '0;
          bytes_left_nxt        = left_dec;
          emit                  = 1'b1;
          res_item.message_byte = byte_full;
          if (left_dec == 32'd0) begin
            res_item.last_of_message = 1'b1;
            phase_nxt                = PH_DONE;
          end
        end else begin
          byte_gather_nxt  = byte_full;
          chunk_offset_nxt = off_sum[4:0];
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_MODE;
      symbol_width_r  <= '0;
      length_gather_r <= '0;
      chunk_offset_r  <= '0;
      byte_gather_r   <= '0;
      bytes_left_r    <= '0;
    end else if (advance) begin
      phase_r         <= phase_nxt;
      symbol_width_r  <= symbol_width_nxt;
      length_gather_r <= length_gather_nxt;
      chunk_offset_r  <= chunk_offset_nxt;
      byte_gather_r   <= byte_gather_nxt;
      bytes_left_r    <= bytes_left_nxt;
    end
  end

  // result register: load on advance, drain on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item_r <= res_item;
    end
  end

`ifndef SYNTHESIS
  // status-only results always close the image
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status != lsbse_pkg::ST_DATA)
      |-> out_item_r.last_of_message)
    else $error("status result without last flag");

  // status-only results carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status != lsbse_pkg::ST_DATA)
      |-> (out_item_r.message_byte == 8'd0))
    else $error("status result with nonzero byte");

  // trailing bytes after the final result produce nothing
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (phase_r == PH_DONE) && !s_item_r.first_of_image |=> !out_valid_r)
    else $error("result emitted for a trailing byte");

  // the input side only stalls with a byte waiting in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s_valid_r && out_valid_r && out_stall)
    else $error("input stall without a blocked result");
`endif

endmodule

// ===== tb/sv/tb_lsb_stego_extractor.sv =====
// ----------------------------------------------------------------------------
// tb_lsb_stego_extractor
// Self-checking bench for the lsb stego extractor. A queue-fed driver streams
// cover image bytes under random gaps, a parser model predicts the result of
// every byte transfer, and a monitor under random stalls compares each result
// transfer field by field with the oldest prediction. Image sizes are changed
// between passes while the block is idle.
// ----------------------------------------------------------------------------
module tb_lsb_stego_extractor;

  localparam int unsigned STUCK_LIMIT    = 2000;
  localparam int unsigned ITEMS_PER_PASS = 400;
  localparam int unsigned SETTLE_CYCLES  = 4;

  // symbol width codes carried in the low bits of the mode byte
  localparam logic [1:0] WCODE_1BIT = 2'd0;
  localparam logic [1:0] WCODE_2BIT = 2'd1;
  localparam logic [1:0] WCODE_BAD  = 2'd2;
  localparam logic [1:0] WCODE_4BIT = 2'd3;

  typedef enum logic [1:0] {WAIT_MODE, GET_LEN, GET_MSG, SKIP_REST} parse_e;

  typedef struct {
    lsbse_pkg::in_item_t item;
    bit                  drain;  // hold back until no result is outstanding
  } stim_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  lsbse_pkg::in_item_t             in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  lsbse_pkg::out_item_t            out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lsbse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lsbse_pkg::DIM_W-1:0]     cfg_data  = '0;

  stim_t                cover_q[$];
  lsbse_pkg::out_item_t msg_q[$];
  int unsigned          send_gap_pct = 32;
  int unsigned          recv_gap_pct = 51;
  int unsigned          n_errors     = 0;
  int unsigned          n_queued     = 0;
  int unsigned          n_accepted   = 0;
  int unsigned          stuck_cycles = 0;

  // parser model state and its copy of the image size
  parse_e                      parse_st    = WAIT_MODE;
  logic [2:0]                  sym_bits    = '0;
  logic [31:0]                 len_acc     = '0;
  logic [4:0]                  bit_pos     = '0;
  logic [7:0]                  byte_acc    = '0;
  logic [31:0]                 bytes_to_go = '0;
  logic [lsbse_pkg::DIM_W-1:0] img_w       = 15'd1;
  logic [lsbse_pkg::DIM_W-1:0] img_h       = 15'd1;

  lsb_stego_extractor DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // message capacity in bytes, wrapped to 32 bits when negative
  function automatic logic [31:0] msg_capacity(input logic [2:0] k);
    logic [63:0] total;
    logic [63:0] c;
    total = 64'(img_w) * 64'(img_h) * 64'd4;
    case (k)
      3'd1: c = total / 64'd8 - 64'd33;
      3'd2: c = total / 64'd4 - 64'd17;
      default: c = total / 64'd2 - 64'd9;
    endcase
    return c[31:0];
  endfunction

  function automatic lsbse_pkg::out_item_t result_of(input logic [7:0] b,
      input logic last, input logic [lsbse_pkg::STATUS_W-1:0] st);
    lsbse_pkg::out_item_t r;
    r.message_byte    = b;
    r.last_of_message = last;
    r.status          = st;
    return r;
  endfunction

  // advance the parser model by one cover byte
  task automatic extract_step(input lsbse_pkg::in_item_t it, output bit got,
                              output lsbse_pkg::out_item_t res);
    logic [7:0]  mask;
    logic [31:0] chunk;
    logic [31:0] want_len;
    got = 1'b0;
    res = '0;
    mask = (sym_bits == 3'd1) ? 8'h01 : (sym_bits == 3'd2) ? 8'h03 : 8'h0f;
    chunk = 32'(it.cover_byte & mask);
    if (it.first_of_image) parse_st = WAIT_MODE;
    case (parse_st)
      WAIT_MODE: begin
        len_acc     = '0;
        bit_pos     = '0;
        byte_acc    = '0;
        bytes_to_go = '0;
        sym_bits    = {1'b0, it.cover_byte[1:0]} + 3'd1;
        if (64'(img_w) * 64'(img_h) < 64'd5) begin
          parse_st = SKIP_REST;
          got = 1'b1;
          res = result_of(8'd0, 1'b1, lsbse_pkg::ST_SMALL);
        end else if (it.cover_byte[1:0] == WCODE_BAD) begin
          parse_st = SKIP_REST;
          got = 1'b1;
          res = result_of(8'd0, 1'b1, lsbse_pkg::ST_BADW);
        end else begin
          parse_st = GET_LEN;
        end
      end
      GET_LEN: begin
        len_acc = len_acc | (chunk << bit_pos);
        if (bit_pos + sym_bits >= 32) begin
          // length arrives in network order
          want_len = {len_acc[7:0], len_acc[15:8], len_acc[23:16], len_acc[31:24]};
          bit_pos = '0;
          if (want_len > msg_capacity(sym_bits)) begin
            parse_st = SKIP_REST;
            got = 1'b1;
            res = result_of(8'd0, 1'b1, lsbse_pkg::ST_LONG);
          end else if (want_len == 32'd0) begin
            parse_st = SKIP_REST;
            got = 1'b1;
            res = result_of(8'd0, 1'b1, lsbse_pkg::ST_EMPTY);
          end else begin
            bytes_to_go = want_len;
            byte_acc    = '0;
            parse_st    = GET_MSG;
          end
        end else begin
          bit_pos = bit_pos + sym_bits;
        end
      end
      GET_MSG: begin
        byte_acc = byte_acc | 8'(chunk << bit_pos[2:0]);
        if (bit_pos + sym_bits >= 8) begin
          bytes_to_go = bytes_to_go - 32'd1;
          got = 1'b1;
          res = result_of(byte_acc, bytes_to_go == 32'd0, lsbse_pkg::ST_DATA);
          if (bytes_to_go == 32'd0) parse_st = SKIP_REST;
          bit_pos  = '0;
          byte_acc = '0;
        end else begin
          bit_pos = bit_pos + sym_bits;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic first, input bit drain);
    stim_t s;
    s.item.cover_byte     = b;
    s.item.first_of_image = first;
    s.drain               = drain;
    cover_q.push_back(s);
    n_queued++;
  endtask

  // one image stream: mode byte, then (for a valid width code) length and n_data
  // message bytes, then trailing bytes; cut > 0 keeps only the first cut bytes
  task automatic queue_image(input logic [1:0] code, input logic [31:0] msg_len,
                             input int unsigned n_data, input int unsigned n_trail,
                             input int unsigned cut, input bit drain);
    logic [7:0]  mask;
    logic [7:0]  msg;
    logic [31:0] wire_len;
    int unsigned k;
    logic [7:0]  seq[$];
    k = int'(code) + 1;
    mask = (k == 1) ? 8'h01 : (k == 2) ? 8'h03 : 8'h0f;
    seq.push_back({6'($urandom), code});
    if (code != WCODE_BAD) begin
      wire_len = {msg_len[7:0], msg_len[15:8], msg_len[23:16], msg_len[31:24]};
      for (int i = 0; i < 32; i += k)
        seq.push_back((8'($urandom) & ~mask) | 8'((wire_len >> i) & 32'(mask)));
      for (int m = 0; m < n_data; m++) begin
        msg = 8'($urandom);
        for (int i = 0; i < 8; i += k)
          seq.push_back((8'($urandom) & ~mask) | ((msg >> i) & mask));
      end
    end
    repeat (n_trail) seq.push_back(8'($urandom));
    foreach (seq[i])
      if (cut == 0 || i < cut) queue_byte(seq[i], i == 0, drain && i == 0);
  endtask

  // random images, mostly well formed, with noise and cut-short streams
  task automatic queue_random_images(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n_data;
    int unsigned cut;
    logic [1:0]  code;
    logic [31:0] cap;
    logic [31:0] len;
    stop_at = n_queued + n_items;
    while (n_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'($urandom), 1'b0);
        continue;
      end
      pick = $urandom_range(99);
      code = (pick < 6) ? WCODE_BAD : (pick < 37) ? WCODE_1BIT :
             (pick < 68) ? WCODE_2BIT : WCODE_4BIT;
      cap = msg_capacity({1'b0, code} + 3'd1);
      pick = $urandom_range(99);
      if (pick < 8)
        len = 32'd0;
      else if (pick < 18)
        len = $urandom;
      else if (pick < 28 && cap < 32'd64)
        len = cap + 32'($urandom_range(1, 3));
      else if (pick < 34 && cap < 32'd8 && cap != 32'd0)
        len = cap;
      else
        len = 32'($urandom_range(1, 6));
      n_data = (len > 32'd12) ? $urandom_range(0, 12) : int'(len);
      cut = ($urandom_range(99) < 8) ? $urandom_range(1, 40) : 0;
      queue_image(code, len, n_data, $urandom_range(0, 3), cut, $urandom_range(99) < 4);
    end
  endtask

  // wait until every byte is taken and every result has come, then let the
  // pipeline empty out
  task automatic settle();
    while (n_accepted != n_queued || msg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lsbse_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lsbse_pkg::DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == lsbse_pkg::CFG_IMAGE_WIDTH) img_w = val;
    else img_h = val;
  endtask

  task automatic run_pass(input logic [lsbse_pkg::DIM_W-1:0] w,
                          input logic [lsbse_pkg::DIM_W-1:0] h,
                          input int unsigned send_pct, input int unsigned recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    write_reg(lsbse_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(lsbse_pkg::CFG_IMAGE_HEIGHT, h);
    queue_random_images(ITEMS_PER_PASS);
    settle();
  endtask

  // byte driver: predicts on every input transfer, then offers the next byte
  always @(posedge clk) begin : drive_bytes
    bit                   got;
    lsbse_pkg::out_item_t res;
    stim_t                nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        extract_step(in_data, got, res);
        if (got) msg_q.push_back(res);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (cover_q.size() != 0 && !(cover_q[0].drain && msg_q.size() != 0) &&
            $urandom_range(99) >= send_gap_pct) begin
          nxt = cover_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= nxt.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls
  always @(posedge clk) begin : check_results
    lsbse_pkg::out_item_t want;
    out_stall <= rst_n && ($urandom_range(99) < recv_gap_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (msg_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, out_data);
        n_errors++;
      end else begin
        want = msg_q.pop_front();
        if (out_data.message_byte !== want.message_byte) begin
          $display("%0t: message_byte mismatch: expected %02h, got %02h",
                   $time, want.message_byte, out_data.message_byte);
          n_errors++;
        end
        if (out_data.last_of_message !== want.last_of_message) begin
          $display("%0t: last_of_message mismatch: expected %0b, got %0b",
                   $time, want.last_of_message, out_data.last_of_message);
          n_errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, out_data.status);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("%0t: watchdog: no transfer for %0d cycles", $time, STUCK_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset size 1x1: image too small, mode byte taken without the first flag
    queue_byte(8'hfc, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    settle();

    // 5x1: 4-bit symbols hold one byte, 1- and 2-bit capacities wrap
    write_reg(lsbse_pkg::CFG_IMAGE_WIDTH, 15'd5);
    write_reg(lsbse_pkg::CFG_IMAGE_HEIGHT, 15'd1);
    queue_image(WCODE_4BIT, 32'd1, 1, 0, 0, 1'b0);
    queue_image(WCODE_4BIT, 32'd2, 0, 0, 0, 1'b1);
    queue_image(WCODE_BAD, 32'd0, 0, 1, 0, 1'b0);
    queue_image(WCODE_4BIT, 32'd0, 0, 0, 0, 1'b0);
    settle();

    run_pass(15'd16384, 15'd16383, 32, 51);
    run_pass(15'd7, 15'd3, 51, 32);
    run_pass(15'd1, 15'd8, 0, 0);

    if (n_errors == 0 && msg_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
